// File: hw/rtl/fpp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the framed packet parser with CRC-16.
// No dependencies; used by the interfaces, the CRC unit and the top level.

package fpp_pkg;

   localparam int BufferBytes = 4096;
   localparam logic [15:0] MaxLength = 16'(BufferBytes - 4);
   localparam logic [15:0] CrcPoly = 16'h8408;

   localparam int ByteWidth   = 8;
   localparam int EventWidth  = 3;
   localparam int OffsetWidth = 12;
   localparam int LengthWidth = 16;
   localparam int CrcWidth    = 16;
   localparam int CsrIdxWidth = 2;

   localparam logic [ByteWidth-1:0] SyncFirstReset  = 8'hFF;
   localparam logic [ByteWidth-1:0] SyncSecondReset = 8'h5A;
   localparam logic [ByteWidth-1:0] EndByteReset    = 8'h33;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_END_BYTE    = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_SYNC1 = 4'd0,
      PH_SYNC2 = 4'd1,
      PH_ID    = 4'd2,
      PH_CLASS = 4'd3,
      PH_LEN1  = 4'd4,
      PH_LEN2  = 4'd5,
      PH_DATA  = 4'd6,
      PH_CRC1  = 4'd7,
      PH_CRC2  = 4'd8,
      PH_END   = 4'd9
   } phase_type;

   typedef enum logic [EventWidth-1:0] {
      EV_HUNT    = 3'd0,
      EV_HEADER  = 3'd1,
      EV_PAYLOAD = 3'd2,
      EV_GOOD    = 3'd3,
      EV_CRC_ERR = 3'd4,
      EV_END_ERR = 3'd5,
      EV_LEN_ERR = 3'd6
   } event_type;

endpackage

// File: hw/rtl/fpp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and parser results.
// Depends on fpp_pkg for field widths.

interface fpp_req_if;
   logic                             valid;
   logic                             ready;
   logic [fpp_pkg::ByteWidth-1:0]    rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [fpp_pkg::EventWidth-1:0]     event_res;
   logic [fpp_pkg::ByteWidth-1:0]      payload_byte;
   logic [fpp_pkg::OffsetWidth-1:0]    payload_offset;
   logic [fpp_pkg::ByteWidth-1:0]      msg_id;
   logic [fpp_pkg::ByteWidth-1:0]      msg_class;
   logic [fpp_pkg::LengthWidth-1:0]    msg_length;

   modport source (output valid, output event_res, output payload_byte,
                   output payload_offset, output msg_id, output msg_class,
                   output msg_length, input ready);
   modport sink   (input valid, input event_res, input payload_byte,
                   input payload_offset, input msg_id, input msg_class,
                   input msg_length, output ready);
endinterface

// File: hw/rtl/framed_packet_parser_crc16.sv
`timescale 1ns / 1ps
// Framed packet parser: one received byte in, one result out, per transfer.
// Depends on fpp_pkg, fpp_if (fpp_req_if, fpp_rsp_if) and fpp_crc16_byte.

// The parser hunts for two sync bytes, then reads message id, class, a
// little-endian 16-bit payload length, the payload, a little-endian CRC-16
// (reflected, poly 0x8408, init 0, over id, class, length and payload) and a
// closing end byte. Every accepted byte yields exactly one result carrying an
// event code, the payload byte and its offset when it is payload, and the
// current frame id, class and length. A frame ends with good, CRC error, end
// error or length error (length above buffer capacity minus four), and the
// parser always falls back to hunting. Throughput is one byte per clock: the
// frame state and the bytewise CRC step are applied in the cycle of the
// transfer and the result lands in a single output register in the cycle after.
// The input side stays ready whenever that register is empty or being taken
// in the same cycle, so a stalled result sink stalls the byte stream directly.
// The user must write sync and end byte values via the csr port only while idle; not enforced.

module framed_packet_parser_crc16 (
   input  logic                                clock,
   input  logic                                reset,
   fpp_req_if.sink                             req_ch,
   fpp_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [fpp_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [fpp_pkg::ByteWidth-1:0]       csr_wdata
);

   // Configuration registers.
   logic [fpp_pkg::ByteWidth-1:0] sync_first_ff;
   logic [fpp_pkg::ByteWidth-1:0] sync_second_ff;
   logic [fpp_pkg::ByteWidth-1:0] end_byte_ff;

   // Frame state.
   fpp_pkg::phase_type                phase_ff, phase_in;
   logic [fpp_pkg::OffsetWidth-1:0]   count_ff, count_in;
   logic [fpp_pkg::ByteWidth-1:0]     id_ff, id_in;
   logic [fpp_pkg::ByteWidth-1:0]     class_ff, class_in;
   logic [fpp_pkg::LengthWidth-1:0]   length_ff, length_in;
   logic [fpp_pkg::CrcWidth-1:0]      crc_ff, crc_in;
   logic [fpp_pkg::ByteWidth-1:0]     crc_lo_ff, crc_lo_in;

   // Result register.
   logic                              rsp_valid_ff;
   logic [fpp_pkg::EventWidth-1:0]    event_ff;
   logic [fpp_pkg::ByteWidth-1:0]     pbyte_ff;
   logic [fpp_pkg::OffsetWidth-1:0]   poff_ff;
   logic [fpp_pkg::ByteWidth-1:0]     rsp_id_ff;
   logic [fpp_pkg::ByteWidth-1:0]     rsp_class_ff;
   logic [fpp_pkg::LengthWidth-1:0]   rsp_length_ff;

   // Step results.
   fpp_pkg::event_type                ev;
   logic [fpp_pkg::ByteWidth-1:0]     pbyte;
   logic [fpp_pkg::OffsetWidth-1:0]   poff;

   logic [fpp_pkg::ByteWidth-1:0]     rx;
   logic [fpp_pkg::CrcWidth-1:0]      crc_step;
   logic [fpp_pkg::LengthWidth-1:0]   length_full;
   logic [fpp_pkg::OffsetWidth:0]     count_inc;
   logic                              req_fire;

   assign rx = req_ch.rx_byte;

   // Accept a byte whenever the result register is free or drains this cycle.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Complete length once the high byte arrives; count after this payload byte.
   assign length_full = {rx, length_ff[fpp_pkg::ByteWidth-1:0]};
   assign count_inc   = {1'b0, count_ff} + 1'b1;

   fpp_crc16_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (rx),
      .crc_next  (crc_step)
   );

   // Next phase.
   always_comb begin
      case (phase_ff)
         fpp_pkg::PH_SYNC1: begin
            phase_in = (rx == sync_first_ff) ? fpp_pkg::PH_SYNC2 : fpp_pkg::PH_SYNC1;
         end
         fpp_pkg::PH_SYNC2: begin
            // A wrong second sync byte drops back to hunting without a recheck.
            phase_in = (rx == sync_second_ff) ? fpp_pkg::PH_ID : fpp_pkg::PH_SYNC1;
         end
         fpp_pkg::PH_ID:    phase_in = fpp_pkg::PH_CLASS;
         fpp_pkg::PH_CLASS: phase_in = fpp_pkg::PH_LEN1;
         fpp_pkg::PH_LEN1:  phase_in = fpp_pkg::PH_LEN2;
         fpp_pkg::PH_LEN2: begin
            if (length_full > fpp_pkg::MaxLength) begin
               phase_in = fpp_pkg::PH_SYNC1;
            end else if (length_full == '0) begin
               phase_in = fpp_pkg::PH_CRC1;
            end else begin
               phase_in = fpp_pkg::PH_DATA;
            end
         end
         fpp_pkg::PH_DATA: begin
            phase_in = (fpp_pkg::LengthWidth'(count_inc) >= length_ff) ?
                       fpp_pkg::PH_CRC1 : fpp_pkg::PH_DATA;
         end
         fpp_pkg::PH_CRC1: phase_in = fpp_pkg::PH_CRC2;
         fpp_pkg::PH_CRC2: begin
            phase_in = ({rx, crc_lo_ff} == crc_ff) ? fpp_pkg::PH_END : fpp_pkg::PH_SYNC1;
         end
         fpp_pkg::PH_END:  phase_in = fpp_pkg::PH_SYNC1;
         default:          phase_in = fpp_pkg::PH_SYNC1;
      endcase
   end

   // Event code, payload forwarding and frame field updates.
   always_comb begin
      ev        = fpp_pkg::EV_HEADER;
      pbyte     = '0;
      poff      = '0;
      count_in  = count_ff;
      id_in     = id_ff;
      class_in  = class_ff;
      length_in = length_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      case (phase_ff)
         fpp_pkg::PH_SYNC1: begin
            if (rx == sync_first_ff) begin
               // New frame: clear everything it accumulates.
               count_in  = '0;
               id_in     = '0;
               class_in  = '0;
               length_in = '0;
               crc_in    = '0;
               crc_lo_in = '0;
            end else begin
               ev = fpp_pkg::EV_HUNT;
            end
         end
         fpp_pkg::PH_SYNC2: begin
            if (rx != sync_second_ff) begin
               ev = fpp_pkg::EV_HUNT;
            end
         end
         fpp_pkg::PH_ID: begin
            id_in  = rx;
            crc_in = crc_step;
         end
         fpp_pkg::PH_CLASS: begin
            class_in = rx;
            crc_in   = crc_step;
         end
         fpp_pkg::PH_LEN1: begin
            length_in = {{(fpp_pkg::LengthWidth - fpp_pkg::ByteWidth){1'b0}}, rx};
            crc_in    = crc_step;
         end
         fpp_pkg::PH_LEN2: begin
            length_in = length_full;
            crc_in    = crc_step;
            count_in  = '0;
            if (length_full > fpp_pkg::MaxLength) begin
               ev = fpp_pkg::EV_LEN_ERR;
            end
         end
         fpp_pkg::PH_DATA: begin
            ev       = fpp_pkg::EV_PAYLOAD;
            pbyte    = rx;
            poff     = count_ff;
            crc_in   = crc_step;
            // Length is capped below the buffer size, so the count never wraps.
            count_in = count_inc[fpp_pkg::OffsetWidth-1:0];
         end
         fpp_pkg::PH_CRC1: begin
            crc_lo_in = rx;
         end
         fpp_pkg::PH_CRC2: begin
            if ({rx, crc_lo_ff} != crc_ff) begin
               ev = fpp_pkg::EV_CRC_ERR;
            end
         end
         fpp_pkg::PH_END: begin
            ev = (rx == end_byte_ff) ? fpp_pkg::EV_GOOD : fpp_pkg::EV_END_ERR;
         end
         default: begin
            ev = fpp_pkg::EV_HUNT;
         end
      endcase
   end

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= fpp_pkg::SyncFirstReset;
         sync_second_ff <= fpp_pkg::SyncSecondReset;
         end_byte_ff    <= fpp_pkg::EndByteReset;
      end else if (csr_we) begin
         case (csr_index)
            fpp_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            fpp_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            fpp_pkg::CSR_END_BYTE:    end_byte_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame state advances only on an input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= fpp_pkg::PH_SYNC1;
         count_ff  <= '0;
         id_ff     <= '0;
         class_ff  <= '0;
         length_ff <= '0;
         crc_ff    <= '0;
         crc_lo_ff <= '0;
      end else if (req_fire) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         id_ff     <= id_in;
         class_ff  <= class_in;
         length_ff <= length_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

   // Result valid: set by an input transfer, drop when the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload: load with the state as it stands after this byte.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         event_ff      <= ev;
         pbyte_ff      <= pbyte;
         poff_ff       <= poff;
         rsp_id_ff     <= id_in;
         rsp_class_ff  <= class_in;
         rsp_length_ff <= length_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.event_res      = event_ff;
   assign rsp_ch.payload_byte   = pbyte_ff;
   assign rsp_ch.payload_offset = poff_ff;
   assign rsp_ch.msg_id         = rsp_id_ff;
   assign rsp_ch.msg_class      = rsp_class_ff;
   assign rsp_ch.msg_length     = rsp_length_ff;

endmodule

// File: hw/rtl/fpp_crc16_byte.sv
`timescale 1ns / 1ps
// Bytewise reflected CRC-16 update (polynomial from fpp_pkg, no final xor).
// Depends on fpp_pkg.

module fpp_crc16_byte (
   input  logic [fpp_pkg::CrcWidth-1:0]  crc_cur,
   input  logic [fpp_pkg::ByteWidth-1:0] data_byte,
   output logic [fpp_pkg::CrcWidth-1:0]  crc_next
);

   always_comb begin
      logic [fpp_pkg::CrcWidth-1:0] acc;
      acc = crc_cur ^ {{(fpp_pkg::CrcWidth - fpp_pkg::ByteWidth){1'b0}}, data_byte};
      for (int k = 0; k < fpp_pkg::ByteWidth; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ fpp_pkg::CrcPoly;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule

// File: tb/fpp_tb_pkg.sv
`timescale 1ns / 1ps
// Testbench types for the framed packet parser: the expected result record
// and the bytewise CRC-16 step. Depends on fpp_pkg for the event codes.

package fpp_tb_pkg;

   import fpp_pkg::*;

   typedef struct packed {
      event_type   ev;
      logic [7:0]  data;
      logic [11:0] offset;
      logic [7:0]  id;
      logic [7:0]  cls;
      logic [15:0] length;
   } parse_result_type;

   // Reflected CRC-16, poly 0x8408, one byte per call.
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ 16'h8408;
         else      c = c >> 1;
      end
      return c;
   endfunction

endpackage

// File: tb/fpp_frame_checker.sv
`timescale 1ns / 1ps
// Frame checker: watches the byte and result channels and the csr port,
// predicts each result and compares it. Depends on fpp_pkg, fpp_tb_pkg, fpp_if.

module fpp_frame_checker
   import fpp_pkg::*;
   import fpp_tb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   fpp_req_if                     req_mon,
   fpp_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]   csr_wdata,
   output int                     fail_count,
   output int                     results_pending
);

   logic [7:0]  sync_first_q, sync_second_q, end_byte_q;
   phase_type   phase_q;
   logic [12:0] count_q;
   logic [7:0]  id_q, cls_q;
   logic [15:0] len_q, crc_q, crc_rx_q;

   parse_result_type expected_results[$];

   initial fail_count = 0;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      fail_count++;
      $display("ERROR [%0t] %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // Advance the parser state by one byte and return the result it causes.
   function automatic parse_result_type predict_result(input logic [7:0] b);
      parse_result_type r;
      r.ev     = EV_HEADER;
      r.data   = 8'h00;
      r.offset = 12'h000;
      case (phase_q)
         PH_SYNC1: begin
            if (b == sync_first_q) begin
               phase_q  = PH_SYNC2;
               count_q  = '0;
               id_q     = '0;
               cls_q    = '0;
               len_q    = '0;
               crc_q    = '0;
               crc_rx_q = '0;
            end else begin
               r.ev = EV_HUNT;
            end
         end
         PH_SYNC2: begin
            if (b == sync_second_q) begin
               phase_q = PH_ID;
            end else begin
               phase_q = PH_SYNC1;
               r.ev    = EV_HUNT;
            end
         end
         PH_ID: begin
            id_q    = b;
            crc_q   = crc16_step(crc_q, b);
            phase_q = PH_CLASS;
         end
         PH_CLASS: begin
            cls_q   = b;
            crc_q   = crc16_step(crc_q, b);
            phase_q = PH_LEN1;
         end
         PH_LEN1: begin
            len_q   = {8'h00, b};
            crc_q   = crc16_step(crc_q, b);
            phase_q = PH_LEN2;
         end
         PH_LEN2: begin
            len_q[15:8] = b;
            crc_q       = crc16_step(crc_q, b);
            count_q     = '0;
            if (len_q > MaxLength) begin
               r.ev    = EV_LEN_ERR;
               phase_q = PH_SYNC1;
            end else if (len_q == 16'h0000) begin
               phase_q = PH_CRC1;
            end else begin
               phase_q = PH_DATA;
            end
         end
         PH_DATA: begin
            r.ev     = EV_PAYLOAD;
            r.data   = b;
            r.offset = count_q[11:0];
            crc_q    = crc16_step(crc_q, b);
            count_q  = count_q + 13'd1;
            if ({3'b000, count_q} >= len_q) phase_q = PH_CRC1;
         end
         PH_CRC1: begin
            crc_rx_q = {8'h00, b};
            phase_q  = PH_CRC2;
         end
         PH_CRC2: begin
            crc_rx_q[15:8] = b;
            if (crc_rx_q == crc_q) begin
               phase_q = PH_END;
            end else begin
               r.ev    = EV_CRC_ERR;
               phase_q = PH_SYNC1;
            end
         end
         PH_END: begin
            r.ev    = (b == end_byte_q) ? EV_GOOD : EV_END_ERR;
            phase_q = PH_SYNC1;
         end
         default: begin
            phase_q = PH_SYNC1;
            r.ev    = EV_HUNT;
         end
      endcase
      r.id     = id_q;
      r.cls    = cls_q;
      r.length = len_q;
      return r;
   endfunction

   always @(posedge clock) begin
      parse_result_type want;
      if (reset) begin
         sync_first_q  = SyncFirstReset;
         sync_second_q = SyncSecondReset;
         end_byte_q    = EndByteReset;
         phase_q       = PH_SYNC1;
         count_q       = '0;
         id_q          = '0;
         cls_q         = '0;
         len_q         = '0;
         crc_q         = '0;
         crc_rx_q      = '0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SYNC_FIRST:  sync_first_q  = csr_wdata;
               CSR_SYNC_SECOND: sync_second_q = csr_wdata;
               CSR_END_BYTE:    end_byte_q    = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(predict_result(req_mon.rx_byte));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", 16'(rsp_mon.event_res), 16'h0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.event_res !== want.ev)
                  report_mismatch("event_res", 16'(rsp_mon.event_res), 16'(want.ev));
               if (rsp_mon.payload_byte !== want.data)
                  report_mismatch("payload_byte", 16'(rsp_mon.payload_byte), 16'(want.data));
               if (rsp_mon.payload_offset !== want.offset)
                  report_mismatch("payload_offset", 16'(rsp_mon.payload_offset),
                                  16'(want.offset));
               if (rsp_mon.msg_id !== want.id)
                  report_mismatch("msg_id", 16'(rsp_mon.msg_id), 16'(want.id));
               if (rsp_mon.msg_class !== want.cls)
                  report_mismatch("msg_class", 16'(rsp_mon.msg_class), 16'(want.cls));
               if (rsp_mon.msg_length !== want.length)
                  report_mismatch("msg_length", rsp_mon.msg_length, want.length);
            end
         end
      end
      results_pending <= expected_results.size();
   end

endmodule

// File: tb/tb_framed_packet_parser_crc16.sv
`timescale 1ns / 1ps
// Top of the framed packet parser testbench: clock, reset, byte stimulus,
// csr writes, receiver stalls and the verdict. Depends on fpp_pkg, fpp_tb_pkg,
// fpp_if, fpp_frame_checker and the parser itself.

module tb_framed_packet_parser_crc16;

   import fpp_pkg::*;
   import fpp_tb_pkg::*;

   localparam int CycleLimit     = 500000;
   localparam int PhaseItems     = 180;
   localparam int PhaseCount     = 8;
   localparam int LongHoldCycles = 300;
   localparam int TailCycles     = 4;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_CRC,
      FRAME_BAD_END,
      FRAME_BAD_SYNC,
      FRAME_OVERSIZE
   } frame_kind_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [ByteWidth-1:0]   csr_wdata;

   fpp_req_if req_bus ();
   fpp_rsp_if rsp_bus ();

   int fail_count;
   int results_pending;
   int items_sent;
   int cycle_count;

   // Idle and stall rates, percent; written only by the stimulus process.
   int  send_idle_pct;
   int  rsp_stall_pct;
   // One-shot request for a long receiver hold-off.
   bit  stall_request;

   // Stimulus-side copy of the parser settings, used to build frames.
   logic [7:0] cfg_sync_first;
   logic [7:0] cfg_sync_second;
   logic [7:0] cfg_end_byte;

   framed_packet_parser_crc16 u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fpp_frame_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: end the run as failed once the cycle limit is reached.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Result sink: random stalls, plus one long hold-off on request so that
   // the output register fills and the byte input backs up behind it.
   initial begin
      int  hold_left;
      bit  stall_taken;
      hold_left   = 0;
      stall_taken = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request && !stall_taken) begin
            stall_taken = 1'b1;
            hold_left   = LongHoldCycles;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one byte and hold it until the transfer. Idle cycles go in front,
   // so valid is only lowered in steps where it is not raised again.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // Build and send one frame; broken kinds stop or corrupt where they fail.
   task automatic send_frame(input frame_kind_type kind, input logic [15:0] len,
                             input logic [7:0] id, input logic [7:0] cls);
      logic [15:0] crc;
      logic [7:0]  b;
      send_byte(cfg_sync_first);
      if (kind == FRAME_BAD_SYNC) begin
         do b = 8'($urandom_range(0, 255)); while (b == cfg_sync_second);
         send_byte(b);
         return;
      end
      send_byte(cfg_sync_second);
      crc = 16'h0000;
      crc = crc16_step(crc, id);
      send_byte(id);
      crc = crc16_step(crc, cls);
      send_byte(cls);
      crc = crc16_step(crc, len[7:0]);
      send_byte(len[7:0]);
      crc = crc16_step(crc, len[15:8]);
      send_byte(len[15:8]);
      if (kind == FRAME_OVERSIZE) return;
      for (int i = 0; i < int'(len); i++) begin
         b   = 8'($urandom_range(0, 255));
         crc = crc16_step(crc, b);
         send_byte(b);
      end
      if (kind == FRAME_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
      if (kind == FRAME_BAD_CRC) return;
      b = cfg_end_byte;
      if (kind == FRAME_BAD_END) b = b ^ (8'h01 << $urandom_range(0, 7));
      send_byte(b);
   endtask

   // Mostly short payloads; a few medium ones.
   function automatic logic [15:0] pick_length();
      if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, 16));
      return 16'($urandom_range(17, 96));
   endfunction

   function automatic logic [15:0] pick_oversize();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return MaxLength + 16'd1;
      if (r < 60) return 16'hFFFF;
      return 16'($urandom_range(int'(MaxLength) + 1, 65535));
   endfunction

   // Drop valid, then hold until every expected result has been taken.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   // Write all three registers on back-to-back edges; call only when drained.
   task automatic write_config(input logic [7:0] s1, input logic [7:0] s2,
                               input logic [7:0] eb);
      csr_we    <= 1'b1;
      csr_index <= CSR_SYNC_FIRST;
      csr_wdata <= s1;
      @(posedge clock);
      csr_index <= CSR_SYNC_SECOND;
      csr_wdata <= s2;
      @(posedge clock);
      csr_index <= CSR_END_BYTE;
      csr_wdata <= eb;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_sync_first  = s1;
      cfg_sync_second = s2;
      cfg_end_byte    = eb;
   endtask

   // Random traffic: mostly well-formed frames, the rest broken frames and
   // loose noise bytes, some of which look like a first sync byte.
   task automatic random_traffic(input int count);
      int             target;
      int             pick;
      frame_kind_type kind;
      logic [15:0]    len;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         len  = pick_length();
         if (pick < 70) begin
            kind = FRAME_GOOD;
         end else if (pick < 78) begin
            kind = FRAME_BAD_CRC;
         end else if (pick < 86) begin
            kind = FRAME_BAD_END;
         end else if (pick < 92) begin
            kind = FRAME_BAD_SYNC;
         end else if (pick < 96) begin
            kind = FRAME_OVERSIZE;
            len  = pick_oversize();
         end else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 3) == 0) send_byte(cfg_sync_first);
               else                           send_byte(8'($urandom_range(0, 255)));
            end
            continue;
         end
         send_frame(kind, len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int mode;
      items_sent      = 0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      stall_request   = 1'b0;
      cfg_sync_first  = SyncFirstReset;
      cfg_sync_second = SyncSecondReset;
      cfg_end_byte    = EndByteReset;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_SYNC_FIRST;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.rx_byte   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset settings.
      // Hunting byte that is not a sync byte.
      send_byte(8'h00);
      // Two first-sync bytes in a row: the second fails as second sync and
      // is not taken again as a first sync, so the next 0x5A only hunts.
      send_byte(cfg_sync_first);
      send_byte(cfg_sync_first);
      send_byte(cfg_sync_second);
      // Zero-length frame with extreme id and class: CRC follows the length.
      send_frame(FRAME_GOOD, 16'h0000, 8'h00, 8'hFF);
      // Largest length field, beyond capacity.
      send_frame(FRAME_OVERSIZE, 16'hFFFF, 8'hFF, 8'h00);
      // One payload byte with a corrupted CRC.
      send_frame(FRAME_BAD_CRC, 16'h0001, 8'hA5, 8'h5A);

      // Random phases: cycle through the idling modes and settings.
      for (int p = 0; p < PhaseCount; p++) begin
         mode = p % 4;
         if (p > 0) begin
            wait_drained();
            case (p)
               1:       write_config(8'h00, 8'hFF, 8'h00);
               2:       write_config(8'hFF, 8'h00, 8'hFF);
               default: write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)));
            endcase
         end
         case (mode)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin send_idle_pct = 17; rsp_stall_pct = 17; end
         endcase
         if (p == 0) begin
            // Long receiver hold-off while bytes keep coming.
            stall_request = 1'b1;
            random_traffic(PhaseItems / 2);
         end
         random_traffic(PhaseItems);
      end

      // Drain with the receiver always ready, then let the pipe settle.
      rsp_stall_pct = 0;
      wait_drained();
      repeat (TailCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
